// File: rtl/dllp_pkg.sv
// Dash-list line parser: shared types, constants and result builder.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package dllp_pkg;

	localparam int POS_W = 16;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 3;
	localparam int Q_DEPTH = 3;
	localparam int Q_CNT_W = 2;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [31:0] MAX_TEXT_DEF = 32'd65535;

	localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SP = 8'h20;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

	typedef enum logic [STAT_W-1:0] {
		ST_ITEM     = 3'd0,
		ST_STOP     = 3'd1,
		ST_END      = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NO_ITEMS = 3'd4
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] item_offset;
		logic [POS_W-1:0] item_length;
		logic [POS_W-1:0] item_count;
		logic [POS_W-1:0] consumed_bytes;
		logic             last_of_run;
	} result_t;

	// results raised by one input beat: count 0..2, in order r0 then r1
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t make_result(
		input status_t          st,
		input logic [POS_W-1:0] off,
		input logic [POS_W-1:0] len,
		input logic [POS_W-1:0] cnt,
		input logic [POS_W-1:0] acc,
		input logic             last
	);
		result_t r;
		r.status         = st;
		r.item_offset    = off;
		r.item_length    = len;
		r.item_count     = cnt;
		r.consumed_bytes = acc;
		r.last_of_run    = last;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/dllp_ifs.sv
// Channel interfaces of the dash-list line parser: text input and result output.
// Depends on dllp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dllp_text_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [dllp_pkg::BYTE_W-1:0]  data_byte;

	modport source(output valid, output action, output data_byte, input ready);
	modport sink(input valid, input action, input data_byte, output ready);
endinterface

interface dllp_result_if;
	logic                         valid;
	logic                         ready;
	logic [dllp_pkg::STAT_W-1:0]  status;
	logic [dllp_pkg::POS_W-1:0]   item_offset;
	logic [dllp_pkg::POS_W-1:0]   item_length;
	logic [dllp_pkg::POS_W-1:0]   item_count;
	logic [dllp_pkg::POS_W-1:0]   consumed_bytes;
	logic                         last_of_run;

	modport source(
		output valid, output status, output item_offset, output item_length,
		output item_count, output consumed_bytes, output last_of_run, input ready
	);
	modport sink(
		input valid, input status, input item_offset, input item_length,
		input item_count, input consumed_bytes, input last_of_run, output ready
	);
endinterface

`default_nettype wire

// File: rtl/dllp_parse.sv
// Parser state and per-beat decode: updates line state and raises 0..2 results.
// Depends on dllp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dllp_parse #(
	parameter logic [31:0] MAX_TEXT = dllp_pkg::MAX_TEXT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        action,
	input  logic [dllp_pkg::BYTE_W-1:0] data_byte,
	output logic                        finished,
	output dllp_pkg::push_t             push
);
	import dllp_pkg::*;

	localparam logic [POS_W-1:0] POS_CAP =
		(MAX_TEXT < 32'(POS_MAX)) ? MAX_TEXT[POS_W-1:0] : POS_MAX;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_DASH    = 2'd1,
		PH_CONTENT = 2'd2
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] bp_q, bp_d;
	logic [POS_W-1:0] line_q, line_d;
	logic [POS_W-1:0] cbeg_q, cbeg_d;
	logic [POS_W-1:0] ccnt_q, ccnt_d;
	logic             tcr_q, tcr_d;
	logic             vis_q, vis_d;
	logic [POS_W-1:0] items_q, items_d;
	logic [POS_W-1:0] acc_q, acc_d;
	logic             fin_q, fin_d;

	logic [POS_W-1:0] bp_inc, ccnt_inc, items_inc, len;
	logic             bad, ws;

	always_comb begin
		bp_inc    = (bp_q >= POS_CAP) ? POS_CAP : bp_q + 1'b1;
		ccnt_inc  = (ccnt_q >= POS_CAP) ? POS_CAP : ccnt_q + 1'b1;
		items_inc = (items_q == POS_MAX) ? POS_MAX : items_q + 1'b1;
		len       = ccnt_q - POS_W'(tcr_q);
		bad       = (phase_q == PH_DASH) || !vis_q;
		ws        = data_byte inside {[8'h09:8'h0D], CH_SP};

		phase_d = phase_q;
		bp_d    = bp_q;
		line_d  = line_q;
		cbeg_d  = cbeg_q;
		ccnt_d  = ccnt_q;
		tcr_d   = tcr_q;
		vis_d   = vis_q;
		items_d = items_q;
		acc_d   = acc_q;
		fin_d   = fin_q;
		push    = '0;

		if (fire && !fin_q) begin
			if (action) begin
				fin_d = 1'b1;
				if (phase_q == PH_START) begin
					push.n  = 2'd1;
					push.r0 = make_result((items_q != '0) ? ST_END : ST_NO_ITEMS,
						'0, '0, items_q, acc_q, 1'b1);
				end else if (bad) begin
					push.n  = 2'd1;
					push.r0 = make_result(ST_EMPTY, '0, '0, items_q, line_q, 1'b1);
				end else begin
					items_d = items_inc;
					acc_d   = bp_q;
					push.n  = 2'd2;
					push.r0 = make_result(ST_ITEM, cbeg_q, len, items_inc, bp_q, 1'b0);
					push.r1 = make_result(ST_END, '0, '0, items_inc, bp_q, 1'b1);
				end
			end else begin
				bp_d = bp_inc;
				if (phase_q == PH_START) begin
					if (data_byte != CH_DASH) begin
						fin_d   = 1'b1;
						push.n  = 2'd1;
						push.r0 = make_result((items_q != '0) ? ST_STOP : ST_NO_ITEMS,
							'0, '0, items_q, acc_q, 1'b1);
					end else begin
						phase_d = PH_DASH;
						line_d  = bp_q;
						cbeg_d  = bp_inc;
						ccnt_d  = '0;
						tcr_d   = 1'b0;
						vis_d   = 1'b0;
					end
				end else if (data_byte == CH_LF) begin
					phase_d = PH_START;
					push.n  = 2'd1;
					if (bad) begin
						fin_d   = 1'b1;
						push.r0 = make_result(ST_EMPTY, '0, '0, items_q, line_q, 1'b1);
					end else begin
						items_d = items_inc;
						acc_d   = bp_inc;
						push.r0 = make_result(ST_ITEM, cbeg_q, len, items_inc, bp_inc, 1'b1);
					end
				end else if (phase_q == PH_DASH && data_byte == CH_SP) begin
					cbeg_d  = bp_inc;
					phase_d = PH_CONTENT;
				end else begin
					phase_d = PH_CONTENT;
					ccnt_d  = ccnt_inc;
					tcr_d   = (data_byte == CH_CR);
					if (!ws) begin
						vis_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			bp_q    <= '0;
			line_q  <= '0;
			cbeg_q  <= '0;
			ccnt_q  <= '0;
			tcr_q   <= 1'b0;
			vis_q   <= 1'b0;
			items_q <= '0;
			acc_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			line_q  <= line_d;
			cbeg_q  <= cbeg_d;
			ccnt_q  <= ccnt_d;
			tcr_q   <= tcr_d;
			vis_q   <= vis_d;
			items_q <= items_d;
			acc_q   <= acc_d;
			fin_q   <= fin_d;
		end
	end

	assign finished = fin_q;

endmodule

`default_nettype wire

// File: rtl/dllp_outq.sv
// Result queue: three-entry shift queue that takes up to two results per cycle.
// Depends on dllp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dllp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  dllp_pkg::push_t   push,
	output logic              room,
	output logic              valid,
	input  logic              ready,
	output dllp_pkg::result_t head
);
	import dllp_pkg::*;

	result_t [Q_DEPTH-1:0] ent_q, ent_d;
	logic [Q_CNT_W-1:0]    cnt_q, cnt_d;
	logic [Q_CNT_W-1:0]    base;
	logic                  pop;

	always_comb begin
		pop   = (cnt_q != '0) && ready;
		base  = cnt_q - Q_CNT_W'(pop);
		cnt_d = base + push.n;
		ent_d = pop ? (ent_q >> $bits(result_t)) : ent_q;
		if (push.n != 2'd0) begin
			ent_d[base] = push.r0;
		end
		if (push.n == 2'd2) begin
			ent_d[base + 1'b1] = push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	// room for a double beat this cycle
	assign room  = (cnt_q <= Q_CNT_W'(1));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[0];

endmodule

`default_nettype wire

// File: rtl/dash_list_line_parser_core.sv
// Dash-list line parser top level: parser state plus result queue.
// Depends on dllp_pkg, dllp_ifs, dllp_parse and dllp_outq.
//
// Takes one text beat (or the end-of-input beat) per clock while input ready
// is high and reports each dash-list item as offset and length of its stripped
// content, then a final status beat. Each text beat is decoded in the cycle it
// is taken and its results land in a three-entry result queue, so the sustained
// rate is one input beat per cycle while the result side drains. Input ready
// drops only when the queue holds two or more beats. End of input inside a line
// that holds an item yields two result beats, the item then the final status.
// After the final status the block keeps taking input and drops it until reset.
`timescale 1ns / 1ps
`default_nettype none

module dash_list_line_parser_core #(
	parameter logic [31:0] MAX_TEXT = dllp_pkg::MAX_TEXT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dllp_text_if.sink     text_ch,
	dllp_result_if.source result_ch
);
	import dllp_pkg::*;

	push_t   push;
	result_t head;
	logic    fire, finished, room;

	assign text_ch.ready = finished || room;
	assign fire          = text_ch.valid && text_ch.ready;

	dllp_parse #(
		.MAX_TEXT(MAX_TEXT)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.action   (text_ch.action),
		.data_byte(text_ch.data_byte),
		.finished (finished),
		.push     (push)
	);

	dllp_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.valid (result_ch.valid),
		.ready (result_ch.ready),
		.head  (head)
	);

	assign result_ch.status         = head.status;
	assign result_ch.item_offset    = head.item_offset;
	assign result_ch.item_length    = head.item_length;
	assign result_ch.item_count     = head.item_count;
	assign result_ch.consumed_bytes = head.consumed_bytes;
	assign result_ch.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// File: rtl/dllp_checker.sv
// Port-level checks for the dash-list line parser, bound to the top level.
// Depends on dllp_pkg and dash_list_line_parser_core.
`timescale 1ns / 1ps
`default_nettype none

module dllp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [dllp_pkg::STAT_W-1:0] status,
	input logic [dllp_pkg::POS_W-1:0]  item_offset,
	input logic [dllp_pkg::POS_W-1:0]  item_length,
	input logic [dllp_pkg::POS_W-1:0]  item_count,
	input logic [dllp_pkg::POS_W-1:0]  consumed_bytes,
	input logic                        last_of_run
);
	import dllp_pkg::*;

	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ITEM |-> last_of_run)
		else $error("final status beat without last_of_run");

	a_final_no_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ITEM |-> item_offset == '0 && item_length == '0)
		else $error("status beat carries offset or length");

	a_quiet_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && status != ST_ITEM |=> !out_valid)
		else $error("result beat after final status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(item_offset) && $stable(item_length) && $stable(item_count)
			&& $stable(consumed_bytes) && $stable(last_of_run))
		else $error("stalled result beat changed");

endmodule

bind dash_list_line_parser_core dllp_checker u_dllp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result_ch.valid),
	.out_ready     (result_ch.ready),
	.status        (result_ch.status),
	.item_offset   (result_ch.item_offset),
	.item_length   (result_ch.item_length),
	.item_count    (result_ch.item_count),
	.consumed_bytes(result_ch.consumed_bytes),
	.last_of_run   (result_ch.last_of_run)
);

`default_nettype wire

// File: test/tb_top.sv
// Testbench for dash_list_line_parser_core: directed rows, then random dash-list text.
// Uses dllp_pkg and dllp_ifs; checks every result beat against a line parser or typed row.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import dllp_pkg::*;

	localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF = 8'h0C;
	localparam int CALM_LO = 800;
	localparam int CALM_HI = 2000;
	localparam int BODY_BEATS = 2000;

	typedef enum logic [1:0] {
		AT_LINE_START,
		AFTER_DASH,
		IN_CONTENT
	} line_phase_t;

	typedef struct packed {
		logic act;
		logic [BYTE_W-1:0] data_byte;
		logic typed;
		result_t want;
	} stim_row_t;

	typedef struct packed {
		logic typed;
		result_t want;
	} beat_note_t;

	logic clk = 1'b0;
	logic arst_n;

	dllp_text_if text_ch();
	dllp_result_if result_ch();

	dash_list_line_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_ch(text_ch),
		.result_ch(result_ch)
	);

	always #1 clk = ~clk;

	// line parser state
	line_phase_t phase = AT_LINE_START;
	logic [POS_W-1:0] byte_pos = '0;
	logic [POS_W-1:0] line_start = '0;
	logic [POS_W-1:0] content_start = '0;
	logic [POS_W-1:0] content_len = '0;
	logic ends_in_cr = 1'b0;
	logic has_visible = 1'b0;
	logic [POS_W-1:0] items_taken = '0;
	logic [POS_W-1:0] taken_end = '0;
	logic stopped = 1'b0;

	result_t reports_due[$];
	beat_note_t beat_notes[$];
	int fail_count = 0;
	int cycle_no = 0;
	int results_taken = 0;
	int beats_sent = 0;

	function automatic logic [POS_W-1:0] step_sat(input logic [POS_W-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic bit is_blank(input logic [BYTE_W-1:0] b);
		return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic bit take_break();
		if (cycle_no >= CALM_LO && cycle_no <= CALM_HI) begin
			return 1'b0;
		end
		return $urandom_range(99) < 33;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("st=%0d off=%0d len=%0d cnt=%0d acc=%0d last=%0b", r.status,
			r.item_offset, r.item_length, r.item_count, r.consumed_bytes, r.last_of_run);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// accept the current line as an item, or report it as empty
	function automatic status_t close_line(input logic [POS_W-1:0] end_pos, output result_t r);
		r = '0;
		r.item_count = items_taken;
		if (phase == AFTER_DASH || !has_visible) begin
			stopped = 1'b1;
			r.status = ST_EMPTY;
			r.consumed_bytes = line_start;
			return ST_EMPTY;
		end
		items_taken = step_sat(items_taken);
		taken_end = end_pos;
		r.status = ST_ITEM;
		r.item_offset = content_start;
		r.item_length = content_len - ends_in_cr;
		r.item_count = items_taken;
		r.consumed_bytes = taken_end;
		return ST_ITEM;
	endfunction

	task automatic parse_text_beat(input logic act, input logic [BYTE_W-1:0] b,
		output int n, output result_t r0, output result_t r1);
		logic [POS_W-1:0] p;
		r0 = '0;
		r1 = '0;
		n = 0;
		if (stopped) begin
			return;
		end
		if (act) begin
			if (phase == AT_LINE_START) begin
				stopped = 1'b1;
				r0.status = (items_taken != 0) ? ST_END : ST_NO_ITEMS;
				r0.item_count = items_taken;
				r0.consumed_bytes = taken_end;
				r0.last_of_run = 1'b1;
				n = 1;
			end else if (close_line(byte_pos, r0) == ST_EMPTY) begin
				r0.last_of_run = 1'b1;
				n = 1;
			end else begin
				stopped = 1'b1;
				r1.status = ST_END;
				r1.item_count = items_taken;
				r1.consumed_bytes = taken_end;
				r1.last_of_run = 1'b1;
				n = 2;
			end
			return;
		end
		p = byte_pos;
		byte_pos = step_sat(p);
		if (phase == AT_LINE_START) begin
			if (b != CH_DASH) begin
				stopped = 1'b1;
				r0.status = (items_taken != 0) ? ST_STOP : ST_NO_ITEMS;
				r0.item_count = items_taken;
				r0.consumed_bytes = taken_end;
				r0.last_of_run = 1'b1;
				n = 1;
			end else begin
				phase = AFTER_DASH;
				line_start = p;
				content_start = step_sat(p);
				content_len = '0;
				ends_in_cr = 1'b0;
				has_visible = 1'b0;
			end
		end else if (b == CH_LF) begin
			void'(close_line(byte_pos, r0));
			r0.last_of_run = 1'b1;
			phase = AT_LINE_START;
			n = 1;
		end else if (phase == AFTER_DASH && b == CH_SP) begin
			content_start = step_sat(p);
			phase = IN_CONTENT;
		end else begin
			phase = IN_CONTENT;
			content_len = step_sat(content_len);
			ends_in_cr = (b == CH_CR);
			if (!is_blank(b)) begin
				has_visible = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin : watch
		beat_note_t note;
		result_t r0;
		result_t r1;
		result_t got;
		result_t want;
		int n;
		cycle_no <= cycle_no + 1;
		if (text_ch.valid && text_ch.ready) begin
			note = beat_notes.pop_front();
			parse_text_beat(text_ch.action, text_ch.data_byte, n, r0, r1);
			if (note.typed) begin
				reports_due.push_back(note.want);
			end else begin
				if (n > 0) reports_due.push_back(r0);
				if (n > 1) reports_due.push_back(r1);
			end
		end
		if (result_ch.valid && result_ch.ready) begin
			results_taken <= results_taken + 1;
			got.status = status_t'(result_ch.status);
			got.item_offset = result_ch.item_offset;
			got.item_length = result_ch.item_length;
			got.item_count = result_ch.item_count;
			got.consumed_bytes = result_ch.consumed_bytes;
			got.last_of_run = result_ch.last_of_run;
			if (reports_due.size() == 0) begin
				note_failure({"result beat with nothing awaited: ", show(got)});
			end else begin
				want = reports_due.pop_front();
				if (got !== want) begin
					note_failure({"mismatch: want ", show(want), " got ", show(got)});
				end
			end
		end
	end

	task automatic send_beat(input logic act, input logic [BYTE_W-1:0] b, input logic typed,
		input result_t want);
		beat_note_t note;
		if (take_break()) begin
			text_ch.valid <= 1'b0;
			do @(posedge clk); while (take_break());
		end
		note.typed = typed;
		note.want = want;
		beat_notes.push_back(note);
		text_ch.valid <= 1'b1;
		text_ch.action <= act;
		text_ch.data_byte <= b;
		do @(posedge clk); while (!text_ch.ready);
		beats_sent++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_beat(1'b0, b, 1'b0, '0);
	endtask

	task automatic send_end();
		send_beat(1'b1, BYTE_W'($urandom_range(255)), 1'b0, '0);
	endtask

	function automatic logic [BYTE_W-1:0] blank_byte();
		case ($urandom_range(4))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_VT;
			3: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] any_byte();
		logic [BYTE_W-1:0] b;
		case ($urandom_range(5))
			0: return blank_byte();
			1: return CH_DASH;
			default: begin
				do b = BYTE_W'($urandom_range(255)); while (b == CH_LF);
				return b;
			end
		endcase
	endfunction

	// blank lines hold whitespace only; others get at least one visible byte
	task automatic send_dash_line(input int len, input bit spaced, input bit cr_end,
		input bit blank, input bit close);
		logic [BYTE_W-1:0] body[$];
		for (int i = 0; i < len; i++) begin
			body.push_back(blank ? blank_byte() : any_byte());
		end
		if (!blank && len > 0) begin
			body[$urandom_range(len - 1)] = BYTE_W'(8'h21 + $urandom_range(93));
		end
		if (cr_end) body.push_back(CH_CR);
		send_byte(CH_DASH);
		if (spaced) send_byte(CH_SP);
		foreach (body[i]) send_byte(body[i]);
		if (close) send_byte(CH_LF);
	endtask

	function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] b);
		stim_row_t r;
		r = '0;
		r.data_byte = b;
		return r;
	endfunction

	function automatic stim_row_t lf_row(input logic [POS_W-1:0] off, input logic [POS_W-1:0] len,
		input logic [POS_W-1:0] cnt, input logic [POS_W-1:0] acc);
		stim_row_t r;
		r = byte_row(CH_LF);
		r.typed = 1'b1;
		r.want.status = ST_ITEM;
		r.want.item_offset = off;
		r.want.item_length = len;
		r.want.item_count = cnt;
		r.want.consumed_bytes = acc;
		r.want.last_of_run = 1'b1;
		return r;
	endfunction

	initial begin : drain
		bit pressed;
		pressed = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!pressed && results_taken >= 60) begin
				pressed = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			result_ch.ready <= !take_break();
		end
	end

	initial begin : stimulus
		stim_row_t directed_rows[21];
		logic [BYTE_W-1:0] b;
		int guard;
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.action = 1'b0;
		text_ch.data_byte = '0;
		directed_rows = '{
			byte_row(CH_DASH), byte_row(CH_SP), byte_row("x"), byte_row(CH_CR),
			lf_row(16'd2, 16'd1, 16'd1, 16'd5),
			byte_row(CH_DASH), byte_row(8'hFF), byte_row(8'h00),
			lf_row(16'd6, 16'd2, 16'd2, 16'd9),
			byte_row(CH_DASH), byte_row(CH_SP), byte_row(CH_SP), byte_row(CH_TAB),
			byte_row("y"), byte_row(CH_CR), byte_row(CH_CR), byte_row(CH_LF),
			byte_row(CH_DASH), byte_row(CH_DASH), byte_row(8'h7F), byte_row(CH_LF)
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].act, directed_rows[i].data_byte,
				directed_rows[i].typed, directed_rows[i].want);
		end

		while (beats_sent < BODY_BEATS) begin
			send_dash_line($urandom_range(1, 10), 1'($urandom_range(1)),
				$urandom_range(3) == 0, 1'b0, 1'b1);
		end

		repeat (4) send_dash_line($urandom_range(1, 6), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'b0, 1'b1);

		// only one final status per reset, so the ending is picked at random
		case ($urandom_range(4))
			0: send_end();
			1: begin
				send_dash_line($urandom_range(1, 6), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b0, 1'b0);
				send_end();
			end
			2: begin
				send_dash_line($urandom_range(3), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b1, 1'b0);
				send_end();
			end
			3: begin
				do b = BYTE_W'($urandom_range(255)); while (b == CH_DASH);
				if ($urandom_range(3) == 0) b = CH_LF;
				send_byte(b);
			end
			default: send_dash_line($urandom_range(3), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'b1, 1'b1);
		endcase

		// after the final status everything is dropped
		repeat (16) send_beat(1'($urandom_range(1)), BYTE_W'($urandom_range(255)), 1'b0, '0);
		text_ch.valid <= 1'b0;

		guard = 0;
		while (reports_due.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (16) @(negedge clk);
		if (fail_count == 0 && reports_due.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
